// ===== rtl/core/qpi_pkg.sv =====
`default_nettype none

package qpi_pkg;

  // Operation codes carried in the request's tuser.
  localparam logic [1:0] FUNC_PUSH   = 2'd0;
  localparam logic [1:0] FUNC_POP    = 2'd1;
  localparam logic [1:0] FUNC_INSERT = 2'd2;
  localparam logic [1:0] FUNC_QUERY  = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_BAD_POS = 2'd3;

  // Entries in the command queue between front and back.
  localparam int CQ_DEPTH = 2;

  // Work the back end has to do for one request.
  typedef enum logic [1:0] {
    OP_NONE,      // query or failed request: report only
    OP_APPEND,    // write at the tail
    OP_REMOVE,    // drop the head
    OP_SHIFT_IN   // open a gap by shifting, then write into it
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] value;
    logic [4:0]  position;
    logic [1:0]  status;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        is_empty;
    logic [4:0]  count;
    logic [31:0] back_value;
    logic [31:0] front_value;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/queue_with_positional_insert.sv =====
`default_nettype none

// Bounded first-in first-out queue of DEPTH elements that also inserts at a
// position counted from the front. Each request on the slave stream carries an
// operation (push, pop, insert, query) and answers with one result on the
// master stream: front and back values, element count, empty flag and status.
// A failing request (full, empty, bad position) changes nothing. A front end
// classifies requests against a running count and queues them two deep; the
// back end owns the circular store, which has one write port and one
// registered read port. Push, query, failed requests and a pop that empties
// the queue give their result straight from the idle state; a pop that
// leaves elements first reads the new front from the store; an insert at
// position p below the count n moves the elements from p on up one store
// entry, one per cycle, then writes the value into the gap. The front end
// accepts one request per cycle while its queue has room. A result held by
// the master stream keeps the back end at the step that would emit the next
// result, although an insert still does its shifting in the meantime.

module queue_with_positional_insert
  import qpi_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [39:0] s_tdata,   // value[31:0], position[36:32], zero[39:37]
  input  wire logic [1:0]  s_tuser,   // func[1:0]
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [71:0] m_tdata    // front_value[31:0], back_value[63:32],
                                      // count[68:64], is_empty[69], status[71:70]
);

  logic cq_in_valid;
  logic cq_in_ready;
  cmd_t cq_in_cmd;
  logic cq_out_valid;
  logic cq_out_pop;
  cmd_t cq_out_cmd;
  res_t res;

  // Request classification.
  qpi_front #(
    .DEPTH(DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .func     (s_tuser),
    .value    (s_tdata[31:0]),
    .position (s_tdata[36:32]),
    .cmd_valid(cq_in_valid),
    .cmd_ready(cq_in_ready),
    .cmd      (cq_in_cmd)
  );

  // Command queue between the two halves.
  qpi_cmd_fifo u_cmd_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_valid(cq_in_valid),
    .wr_ready(cq_in_ready),
    .wr_cmd  (cq_in_cmd),
    .rd_valid(cq_out_valid),
    .rd_pop  (cq_out_pop),
    .rd_cmd  (cq_out_cmd)
  );

  // Store and result generation.
  qpi_back #(
    .DEPTH     (DEPTH),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cq_out_valid),
    .cmd      (cq_out_cmd),
    .cmd_pop  (cq_out_pop),
    .res_valid(m_tvalid),
    .res_ready(m_tready),
    .res      (res)
  );

  assign m_tdata = {res.status, res.is_empty, res.count, res.back_value, res.front_value};

endmodule

`default_nettype wire

// ===== rtl/core/qpi_front.sv =====
`default_nettype none

module qpi_front
  import qpi_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic [1:0]  func,
  input  wire logic [31:0] value,
  input  wire logic [4:0]  position,
  output      logic        cmd_valid,
  input  wire logic        cmd_ready,
  output      cmd_t        cmd
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > 5) ? CW : 5;

  // Element count as it stands after every request accepted so far.
  logic [CW-1:0] cnt;
  logic [CW-1:0] cnt_next;
  logic [PW-1:0] pos_w;
  logic [PW-1:0] cnt_w;
  logic          full;
  logic          accept;

  assign in_ready  = cmd_ready;
  assign accept    = in_valid && cmd_ready;
  assign cmd_valid = in_valid;
  assign full      = (cnt == CW'(DEPTH));
  assign pos_w     = PW'(position);
  assign cnt_w     = PW'(cnt);

  // Classify the request against the running count.
  always_comb begin
    cmd.value    = value;
    cmd.position = position;
    cmd.op       = OP_NONE;
    cmd.status   = ST_OK;
    cnt_next     = cnt;
    unique case (func)
      FUNC_PUSH: begin
        if (full) begin
          cmd.status = ST_FULL;
        end else begin
          cmd.op   = OP_APPEND;
          cnt_next = cnt + 1'b1;
        end
      end
      FUNC_POP: begin
        if (cnt == '0) begin
          cmd.status = ST_EMPTY;
        end else begin
          cmd.op   = OP_REMOVE;
          cnt_next = cnt - 1'b1;
        end
      end
      FUNC_INSERT: begin
        if (full) begin
          cmd.status = ST_FULL;
        end else if (pos_w > cnt_w) begin
          cmd.status = ST_BAD_POS;
        end else begin
          // Inserting at the back is a plain append.
          cmd.op   = (pos_w == cnt_w) ? OP_APPEND : OP_SHIFT_IN;
          cnt_next = cnt + 1'b1;
        end
      end
      FUNC_QUERY: begin
        cmd.op = OP_NONE;
      end
      default: begin
        cmd.op = OP_NONE;
      end
    endcase
  end

  // Running count.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (accept) begin
      cnt <= cnt_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/qpi_cmd_fifo.sv =====
`default_nettype none

module qpi_cmd_fifo
  import qpi_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr_valid,
  output      logic wr_ready,
  input  wire cmd_t wr_cmd,
  output      logic rd_valid,
  input  wire logic rd_pop,
  output      cmd_t rd_cmd
);

  localparam int AW = (CQ_DEPTH > 1) ? $clog2(CQ_DEPTH) : 1;
  localparam int NW = $clog2(CQ_DEPTH + 1);

  cmd_t          entry [CQ_DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [NW-1:0] used;
  logic          do_wr;
  logic          do_rd;

  assign wr_ready = (used != NW'(CQ_DEPTH));
  assign rd_valid = (used != '0);
  assign rd_cmd   = entry[rptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_pop && rd_valid;

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      used <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == AW'(CQ_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= (rptr == AW'(CQ_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        used <= used + 1'b1;
      end else if (do_rd && !do_wr) begin
        used <= used - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      entry[wptr] <= wr_cmd;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/qpi_back.sv =====
`default_nettype none

module qpi_back
  import qpi_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cmd_valid,
  input  wire cmd_t cmd,
  output      logic cmd_pop,
  output      logic res_valid,
  input  wire logic res_ready,
  output      res_t res
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > 5) ? CW : 5;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP_RD,
    S_SHIFT,
    S_PLACE
  } state_t;

  // Circular element store.
  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data;

  state_t                state;
  state_t                state_next;
  logic [AW-1:0]         head;
  logic [CW-1:0]         cnt;
  logic [CW-1:0]         k;
  logic [CW-1:0]         k_next;
  logic [DATA_WIDTH-1:0] front_q;
  logic [DATA_WIDTH-1:0] back_q;

  logic                  we;
  logic [AW-1:0]         waddr;
  logic [DATA_WIDTH-1:0] wdata;
  logic                  re;
  logic [AW-1:0]         raddr;

  logic                  emit;
  logic                  advance_head;
  logic                  can_emit;
  logic [CW-1:0]         post_cnt;
  logic [DATA_WIDTH-1:0] post_front;
  logic [DATA_WIDTH-1:0] post_back;
  logic [DATA_WIDTH-1:0] val;
  logic [63:0]           val_w;
  logic [63:0]           front_w;
  logic [63:0]           back_w;
  logic [PW-1:0]         pos_w;
  logic [CW-1:0]         pos_c;
  logic [PW-1:0]         cnt_w;
  res_t                  res_next;

  // Map an offset from the head to a store index.
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW+1)'(h) + (CW+1)'(off);
    if (s >= (CW+1)'(DEPTH)) begin
      s = s - (CW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign val_w    = 64'(cmd.value);
  assign val      = val_w[DATA_WIDTH-1:0];
  assign pos_w    = PW'(cmd.position);
  assign pos_c    = pos_w[CW-1:0];
  assign can_emit = !res_valid || res_ready;
  assign cmd_pop  = emit;

  // Sequencing of store accesses and result timing.
  always_comb begin
    we           = 1'b0;
    waddr        = slot(head, cnt);
    wdata        = val;
    re           = 1'b0;
    raddr        = slot(head, '0);
    emit         = 1'b0;
    advance_head = 1'b0;
    post_cnt     = cnt;
    post_front   = front_q;
    post_back    = back_q;
    state_next   = state;
    k_next       = k;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.op)
            OP_NONE: begin
              emit = can_emit;
            end
            OP_APPEND: begin
              we        = can_emit;
              emit      = can_emit;
              post_cnt  = cnt + 1'b1;
              post_back = val;
              if (cnt == '0) begin
                post_front = val;
              end
            end
            OP_REMOVE: begin
              if (cnt == CW'(1)) begin
                emit         = can_emit;
                advance_head = 1'b1;
                post_cnt     = '0;
              end else begin
                // Fetch the element that becomes the new front.
                re         = 1'b1;
                raddr      = slot(head, CW'(1));
                state_next = S_POP_RD;
              end
            end
            OP_SHIFT_IN: begin
              re         = 1'b1;
              raddr      = slot(head, cnt - 1'b1);
              k_next     = cnt;
              state_next = S_SHIFT;
            end
            default: begin
              emit = 1'b0;
            end
          endcase
        end
      end
      S_POP_RD: begin
        emit         = can_emit;
        advance_head = 1'b1;
        post_cnt     = cnt - 1'b1;
        post_front   = rd_data;
        if (can_emit) begin
          state_next = S_IDLE;
        end
      end
      S_SHIFT: begin
        // Move one element up while fetching the next one down.
        we    = 1'b1;
        waddr = slot(head, k);
        wdata = rd_data;
        if ((k - 1'b1) > pos_c) begin
          re     = 1'b1;
          raddr  = slot(head, k - CW'(2));
          k_next = k - 1'b1;
        end else begin
          state_next = S_PLACE;
        end
      end
      S_PLACE: begin
        we       = 1'b1;
        waddr    = slot(head, pos_c);
        wdata    = val;
        emit     = can_emit;
        post_cnt = cnt + 1'b1;
        if (pos_c == '0) begin
          post_front = val;
        end
        if (can_emit) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Result fields as they stand after the request.
  assign front_w = 64'(post_front);
  assign back_w  = 64'(post_back);
  assign cnt_w   = PW'(post_cnt);

  always_comb begin
    res_next.status      = cmd.status;
    res_next.is_empty    = (post_cnt == '0);
    res_next.count       = cnt_w[4:0];
    res_next.front_value = (post_cnt == '0) ? '0 : front_w[31:0];
    res_next.back_value  = (post_cnt == '0) ? '0 : back_w[31:0];
  end

  // State, queue bookkeeping and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      k         <= '0;
      head      <= '0;
      cnt       <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      k     <= k_next;
      if (emit) begin
        res_valid <= 1'b1;
        res       <= res_next;
        cnt       <= post_cnt;
        front_q   <= post_front;
        back_q    <= post_back;
        if (advance_head) begin
          head <= slot(head, CW'(1));
        end
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Store write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_data <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/qpi_checker.sv =====
`default_nettype none

module qpi_checker
  import qpi_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [71:0] m_tdata
);

  localparam int          PN       = $clog2(CQ_DEPTH + 2);
  localparam logic [4:0]  FULL_CNT = 5'(DEPTH);

  // Requests taken whose result has not been delivered yet.
  logic [PN-1:0] pending;
  logic          s_acc;
  logic          m_acc;

  assign s_acc = s_tvalid && s_tready;
  assign m_acc = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (s_acc && !m_acc) begin
      pending <= pending + 1'b1;
    end else if (m_acc && !s_acc) begin
      pending <= pending - 1'b1;
    end
  end

  // A result stalled by the sink holds its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // No result appears without a request behind it.
  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> pending != '0)
    else $error("result without pending request");

  // The queue and result register bound the requests in flight.
  a_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= PN'(CQ_DEPTH + 1))
    else $error("too many requests in flight");

  // A full report comes with a full count.
  a_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[71:70] == ST_FULL |-> m_tdata[68:64] == FULL_CNT && !m_tdata[69])
    else $error("full status with wrong count");

  // An empty report comes with an empty queue and zero values.
  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[71:70] == ST_EMPTY |-> m_tdata[69] && m_tdata[63:0] == '0)
    else $error("empty status with held elements");

endmodule

bind queue_with_positional_insert qpi_checker #(
  .DEPTH(DEPTH)
) u_qpi_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);

`default_nettype wire

// ===== tb/queue_result_checker.sv =====
`timescale 1ns / 100ps
`default_nettype none

// Watches both streams of the positional-insert queue. It keeps its own copy
// of the queue, works out the result each accepted request should produce,
// and compares every returned result with the oldest one still awaited.
module queue_result_checker
  import qpi_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [39:0] s_tdata,   // value[31:0], position[36:32], zero[39:37]
  input  wire logic [1:0]  s_tuser,   // func[1:0]
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [71:0] m_tdata,   // front_value[31:0], back_value[63:32],
                                      // count[68:64], is_empty[69], status[71:70]
  output int               mismatches,
  output int               outstanding,
  output logic [4:0]       fill_level,
  output int               results_seen,
  output int               full_hits,
  output int               empty_hits,
  output int               bad_pos_hits
);

  // Shadow copy of the queue contents.
  logic [31:0] shadow_elems [DEPTH];
  int          shadow_head;
  int          shadow_count;

  // Results that accepted requests still owe, oldest first.
  res_t        awaited_q [$];

  initial begin
    mismatches   = 0;
    outstanding  = 0;
    fill_level   = '0;
    results_seen = 0;
    full_hits    = 0;
    empty_hits   = 0;
    bad_pos_hits = 0;
    shadow_head  = 0;
    shadow_count = 0;
  end

  function automatic int ring_slot(input int offset);
    return (shadow_head + offset) % DEPTH;
  endfunction

  // Applies one request to the shadow queue and returns the result it gives.
  function automatic res_t apply_queue_request(input logic [1:0]  func,
                                               input logic [31:0] value,
                                               input logic [4:0]  position);
    res_t       r;
    logic [1:0] st;
    int         k;
    st = ST_OK;
    case (func)
      FUNC_PUSH: begin
        if (shadow_count >= DEPTH) begin
          st = ST_FULL;
        end else begin
          shadow_elems[ring_slot(shadow_count)] = value;
          shadow_count++;
        end
      end
      FUNC_POP: begin
        if (shadow_count == 0) begin
          st = ST_EMPTY;
        end else begin
          shadow_head = ring_slot(1);
          shadow_count--;
        end
      end
      FUNC_INSERT: begin
        // A full queue is reported before a bad position.
        if (shadow_count >= DEPTH) begin
          st = ST_FULL;
        end else if (int'(position) > shadow_count) begin
          st = ST_BAD_POS;
        end else begin
          for (k = shadow_count; k > int'(position); k--) begin
            shadow_elems[ring_slot(k)] = shadow_elems[ring_slot(k - 1)];
          end
          shadow_elems[ring_slot(int'(position))] = value;
          shadow_count++;
        end
      end
      default: begin
      end
    endcase
    if (shadow_count == 0) begin
      r.front_value = '0;
      r.back_value  = '0;
    end else begin
      r.front_value = shadow_elems[ring_slot(0)];
      r.back_value  = shadow_elems[ring_slot(shadow_count - 1)];
    end
    r.count    = shadow_count[4:0];
    r.is_empty = (shadow_count == 0);
    r.status   = st;
    return r;
  endfunction

  task automatic compare_result(input res_t want, input res_t got);
    if (got.front_value !== want.front_value) begin
      $error("front_value: expected %h, actual %h", want.front_value, got.front_value);
      mismatches++;
    end
    if (got.back_value !== want.back_value) begin
      $error("back_value: expected %h, actual %h", want.back_value, got.back_value);
      mismatches++;
    end
    if (got.count !== want.count) begin
      $error("count: expected %0d, actual %0d", want.count, got.count);
      mismatches++;
    end
    if (got.is_empty !== want.is_empty) begin
      $error("is_empty: expected %b, actual %b", want.is_empty, got.is_empty);
      mismatches++;
    end
    if (got.status !== want.status) begin
      $error("status: expected %0d, actual %0d", want.status, got.status);
      mismatches++;
    end
  endtask

  // Results are taken before requests so that an edge carrying both never
  // pairs a result with the request accepted at that same edge.
  always @(posedge clk) begin : watch
    res_t got;
    res_t want;
    if (rst) begin
      shadow_head  = 0;
      shadow_count = 0;
      awaited_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got = res_t'(m_tdata);
        if (awaited_q.size() == 0) begin
          $error("result with no request pending: %h", m_tdata);
          mismatches++;
        end else begin
          want = awaited_q.pop_front();
          compare_result(want, got);
          results_seen++;
          case (want.status)
            ST_FULL:    full_hits++;
            ST_EMPTY:   empty_hits++;
            ST_BAD_POS: bad_pos_hits++;
            default: begin
            end
          endcase
        end
      end
      if (s_tvalid && s_tready) begin
        awaited_q.push_back(apply_queue_request(s_tuser, s_tdata[31:0], s_tdata[36:32]));
      end
    end
    outstanding <= awaited_q.size();
    fill_level  <= shadow_count[4:0];
  end

endmodule

`default_nettype wire

// ===== tb/tb_queue_with_positional_insert.sv =====
`timescale 1ns / 100ps
`default_nettype none

module tb_queue_with_positional_insert;
  import qpi_pkg::*;

  localparam int DEPTH       = 16;
  localparam int RANDOM_REQS = 900;
  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE      = 40;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata  = '0;   // value[31:0], position[36:32], zero[39:37]
  logic [1:0]  s_tuser  = '0;   // func[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;         // front_value[31:0], back_value[63:32],
                                // count[68:64], is_empty[69], status[71:70]

  int          mismatches;
  int          outstanding;
  logic [4:0]  fill_level;
  int          results_seen;
  int          full_hits;
  int          empty_hits;
  int          bad_pos_hits;

  int          n_push   = 0;
  int          n_pop    = 0;
  int          n_insert = 0;
  int          n_query  = 0;
  bit          no_gaps  = 1'b0;
  int          cycles   = 0;

  queue_with_positional_insert #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (32)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  queue_result_checker #(
    .DEPTH (DEPTH)
  ) u_checker (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .fill_level   (fill_level),
    .results_seen (results_seen),
    .full_hits    (full_hits),
    .empty_hits   (empty_hits),
    .bad_pos_hits (bad_pos_hits)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Run-away guard.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Idle length: mostly short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'h0000_0000;
    if (r == 1) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  // The result side stalls in random stretches, some of them very long runs
  // with no stall at all.
  initial begin
    int n;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      m_tready <= 1'b1;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 12);
      repeat (n) @(posedge clk);
      m_tready <= 1'b0;
      repeat (pick_gap()) @(posedge clk);
    end
  end

  // Presents one request and holds it until accepted, then maybe idles.
  task automatic send_request(input logic [1:0] func, input logic [31:0] value,
                              input logic [4:0] position);
    int g;
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= {3'b000, position, value};
    do @(posedge clk); while (!s_tready);
    case (func)
      FUNC_PUSH:   n_push++;
      FUNC_POP:    n_pop++;
      FUNC_INSERT: n_insert++;
      default:     n_query++;
    endcase
    g = (no_gaps || $urandom_range(0, 99) < 55) ? 0 : pick_gap();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Holds the request side back until every result has come out.
  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin : stimulus
    int         i;
    int         r;
    int         mode;
    int         blk;
    int         sent;
    int         t_push;
    int         t_pop;
    int         t_ins;
    logic [4:0] pos;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part: empty-queue corners, inserts at front, middle and back,
    // bad positions, fill to full, then push and insert against a full queue.
    send_request(FUNC_QUERY,  32'h1234_5678, 5'd0);
    send_request(FUNC_POP,    32'h0,         5'd0);
    send_request(FUNC_INSERT, 32'h5555_AAAA, 5'd1);
    send_request(FUNC_INSERT, 32'hFFFF_FFFF, 5'd0);
    send_request(FUNC_PUSH,   32'h0000_0000, 5'd0);
    send_request(FUNC_INSERT, 32'hA5A5_A5A5, 5'd1);
    send_request(FUNC_INSERT, 32'h0BAD_CAFE, 5'd3);
    send_request(FUNC_INSERT, 32'h1111_1111, 5'd31);
    send_request(FUNC_INSERT, 32'h2222_2222, 5'd5);
    send_request(FUNC_INSERT, 32'hC0C0_C0C0, 5'd0);
    send_request(FUNC_POP,    32'h0,         5'd0);
    for (i = 0; i < 12; i++) begin
      if (i % 2 == 0) send_request(FUNC_PUSH, pick_value(), 5'd0);
      else send_request(FUNC_INSERT, pick_value(), 5'((i * 3) % (5 + i)));
    end
    send_request(FUNC_PUSH,   32'hDEAD_BEEF, 5'd0);
    send_request(FUNC_INSERT, 32'hDEAD_BEEF, 5'd31);
    send_request(FUNC_INSERT, 32'hDEAD_BEEF, 5'd0);
    send_request(FUNC_QUERY,  32'h0,         5'd16);
    wait_for_results();

    // Random part in blocks that lean toward filling, draining or neither.
    sent = 0;
    while (sent < RANDOM_REQS) begin
      mode    = $urandom_range(0, 2);
      no_gaps = ($urandom_range(0, 3) == 0);
      blk     = $urandom_range(20, 60);
      case (mode)
        0: begin t_push = 35; t_pop = 50; t_ins = 90; end
        1: begin t_push = 10; t_pop = 70; t_ins = 90; end
        default: begin t_push = 25; t_pop = 50; t_ins = 75; end
      endcase
      for (i = 0; i < blk; i++) begin
        r = $urandom_range(0, 99);
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5, 6: pos = 5'($urandom_range(0, fill_level));
          7: pos = 5'd0;
          8: pos = fill_level;
          default: pos = 5'($urandom_range(0, 31));
        endcase
        if (r < t_push) send_request(FUNC_PUSH, pick_value(), 5'($urandom));
        else if (r < t_pop) send_request(FUNC_POP, pick_value(), 5'($urandom));
        else if (r < t_ins) send_request(FUNC_INSERT, pick_value(), pos);
        else send_request(FUNC_QUERY, pick_value(), 5'($urandom));
        sent++;
      end
      if ($urandom_range(0, 5) == 0) wait_for_results();
    end

    // Drain, then give a late or extra result time to show up.
    no_gaps = 1'b0;
    wait_for_results();
    repeat (SETTLE) @(posedge clk);

    $display("run covered %0d requests (push %0d, pop %0d, insert %0d, query %0d), %0d results",
             n_push + n_pop + n_insert + n_query, n_push, n_pop, n_insert, n_query,
             results_seen);
    $display("rejected requests seen: full %0d, empty %0d, bad position %0d",
             full_hits, empty_hits, bad_pos_hits);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
